### rtl/core/pixel_product_with_error_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel product-with-error block
// Clocked on i_clk; PPE_ASSERT is disabled during reset, PPE_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef PIXEL_PRODUCT_WITH_ERROR_TOP_ASSERT_SVH
`define PIXEL_PRODUCT_WITH_ERROR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PPE_ASSERT(lbl, prop, msg)
`define PPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Widths, constants and item types shared by the pixel product-with-error
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int VAL_W  = 32;
    localparam int ERR_W  = 31;
    localparam int QUAL_W = 16;

    // internal widths
    localparam int MAG_W   = VAL_W;              // magnitude, holds 2^31
    localparam int PROD_W  = MAG_W + ERR_W;      // holds 2^62 and mag*err
    localparam int SQ_W    = 2 * ERR_W;          // square of a cross term
    localparam int ROOT_W  = 32;                 // floor root of the sum
    localparam int RAD_W   = 2 * ROOT_W;         // radicand
    localparam int REM_W   = ROOT_W + 2;         // partial remainder

    // square root pipeline: root bits resolved per stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

    // saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    // rounding addend for the ceiling of a negative product magnitude
    localparam logic [PROD_W-1:0] ROUND_ADD =
        PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    // input item
    typedef struct packed {
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] second_value;
        logic [ERR_W-1:0]        first_error;
        logic [ERR_W-1:0]        second_error;
        logic [QUAL_W-1:0]       first_quality;
        logic [QUAL_W-1:0]       second_quality;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [VAL_W-1:0] product_value;
        logic [ERR_W-1:0]        product_error;
        logic [QUAL_W-1:0]       product_quality;
        logic                    saturated;
    } t_out_item;

    // finished fields that ride along with the error computation
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [QUAL_W-1:0]       quality;
        logic                    val_sat;
        logic                    err_ovf;
    } t_side;

    // front-end result: side fields plus the two error cross terms
    typedef struct packed {
        t_side            side;
        logic [ERR_W-1:0] term_a;
        logic [ERR_W-1:0] term_b;
    } t_mid;

endpackage

`default_nettype wire

### rtl/core/ppe_front.sv
// ----------------------------------------------------------------------------
// ppe_front
// Three-stage front end: magnitudes, the three products, then rounding,
// value saturation and extraction of the error cross terms.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_front
    import ppe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_mid          o_mid
);

    // valid bits, one per stage
    logic [2:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // stage 0: signs and magnitudes
    logic [VAL_W-1:0]  c_a_bits;
    logic [VAL_W-1:0]  c_b_bits;
    logic [MAG_W-1:0]  n_ma;
    logic [MAG_W-1:0]  n_mb;
    logic [MAG_W-1:0]  r_ma;
    logic [MAG_W-1:0]  r_mb;
    logic              r_neg0;
    logic [ERR_W-1:0]  r_ea;
    logic [ERR_W-1:0]  r_eb;
    logic [QUAL_W-1:0] r_q0;

    assign c_a_bits = i_item.first_value;
    assign c_b_bits = i_item.second_value;
    assign n_ma = c_a_bits[VAL_W-1] ? (~c_a_bits + MAG_W'(1)) : c_a_bits;
    assign n_mb = c_b_bits[VAL_W-1] ? (~c_b_bits + MAG_W'(1)) : c_b_bits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_neg0 <= c_a_bits[VAL_W-1] ^ c_b_bits[VAL_W-1];
            r_ea   <= i_item.first_error;
            r_eb   <= i_item.second_error;
            r_q0   <= i_item.first_quality | i_item.second_quality;
        end
    end

    // stage 1: value product and the two cross products
    logic [2*MAG_W-1:0] n_mm;
    logic [PROD_W-1:0]  n_pa;
    logic [PROD_W-1:0]  n_pb;
    logic [PROD_W-1:0]  r_m;
    logic [PROD_W-1:0]  r_pa;
    logic [PROD_W-1:0]  r_pb;
    logic               r_neg1;
    logic [QUAL_W-1:0]  r_q1;

    assign n_mm = r_ma * r_mb;
    assign n_pa = r_ma * r_eb;
    assign n_pb = r_mb * r_ea;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_mm[PROD_W-1:0];     // magnitude product stays below 2^63
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_neg1 <= r_neg0;
            r_q1   <= r_q0;
        end
    end

    // stage 2: round toward minus infinity, saturate, pick cross terms
    logic [PROD_W-1:0] c_rnd;
    logic [PROD_W-1:0] c_qn;
    logic [PROD_W-1:0] c_qp;
    t_mid              n_mid;
    t_mid              r_mid;

    assign c_rnd = r_m + ROUND_ADD;
    assign c_qn  = c_rnd >> FRAC_BITS;
    assign c_qp  = r_m >> FRAC_BITS;

    always_comb begin
        n_mid              = '0;
        n_mid.side.quality = r_q1;
        if (r_neg1) begin
            // negative result: minus the ceiling of the magnitude quotient
            if (c_qn > {{(PROD_W-VAL_W){1'b0}}, VAL_MIN}) begin
                n_mid.side.value   = VAL_MIN;
                n_mid.side.val_sat = 1'b1;
            end else begin
                n_mid.side.value = VAL_W'(0) - c_qn[VAL_W-1:0];
            end
        end else begin
            if (|c_qp[PROD_W-1:VAL_W-1]) begin
                n_mid.side.value   = VAL_MAX;
                n_mid.side.val_sat = 1'b1;
            end else begin
                n_mid.side.value = c_qp[VAL_W-1:0];
            end
        end
        // cross terms overflow past the error range
        n_mid.side.err_ovf = (|r_pa[PROD_W-1:ERR_W+FRAC_BITS])
                           | (|r_pb[PROD_W-1:ERR_W+FRAC_BITS]);
        n_mid.term_a = r_pa[ERR_W+FRAC_BITS-1:FRAC_BITS];
        n_mid.term_b = r_pb[ERR_W+FRAC_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_v[2];
    assign o_mid   = r_mid;

endmodule

`default_nettype wire

### rtl/core/ppe_root.sv
// ----------------------------------------------------------------------------
// ppe_root
// Error back end: squares the cross terms, sums them, then takes the floored
// square root two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_root
    import ppe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_mid        i_mid,
    output logic             o_valid,
    output t_side            o_side,
    output logic [ROOT_W-1:0] o_root
);

    // squares stage
    logic [SQ_W-1:0] n_sqa;
    logic [SQ_W-1:0] n_sqb;
    logic [SQ_W-1:0] r_sqa;
    logic [SQ_W-1:0] r_sqb;
    t_side           r_side_sq;
    logic            r_v_sq;

    assign n_sqa = i_mid.term_a * i_mid.term_a;
    assign n_sqb = i_mid.term_b * i_mid.term_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq <= 1'b0;
        end else if (i_en) begin
            r_v_sq <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqa     <= n_sqa;
            r_sqb     <= n_sqb;
            r_side_sq <= i_mid.side;
        end
    end

    // sum stage
    logic [RAD_W-1:0] n_sum;
    logic [RAD_W-1:0] r_sum;
    t_side            r_side_sum;
    logic             r_v_sum;

    assign n_sum = RAD_W'(r_sqa) + RAD_W'(r_sqb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum <= 1'b0;
        end else if (i_en) begin
            r_v_sum <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= n_sum;
            r_side_sum <= r_side_sq;
        end
    end

    // root stages: remainder and radicand are not needed after the last one
    logic              r_v    [SQRT_STAGES];
    t_side             r_side [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem  [SQRT_STAGES-1];
    logic [RAD_W-1:0]  r_x    [SQRT_STAGES-1];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
        logic              c_v_in;
        t_side             c_side_in;
        logic [REM_W-1:0]  c_rem_in;
        logic [ROOT_W-1:0] c_root_in;
        logic [RAD_W-1:0]  c_x_in;
        logic [REM_W+1:0]  c_try;
        logic [REM_W+1:0]  c_sub;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [RAD_W-1:0]  n_x;

        if (s == 0) begin : g_first
            assign c_v_in    = r_v_sum;
            assign c_side_in = r_side_sum;
            assign c_rem_in  = '0;
            assign c_root_in = '0;
            assign c_x_in    = r_sum;
        end else begin : g_next
            assign c_v_in    = r_v[s-1];
            assign c_side_in = r_side[s-1];
            assign c_rem_in  = r_rem[s-1];
            assign c_root_in = r_root[s-1];
            assign c_x_in    = r_x[s-1];
        end

        // restoring digit steps: bring down two radicand bits, try root*4+1
        always_comb begin
            n_rem  = c_rem_in;
            n_root = c_root_in;
            n_x    = c_x_in;
            c_try  = '0;
            c_sub  = '0;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                c_try = {n_rem, n_x[RAD_W-1 -: 2]};
                c_sub = (REM_W+2)'({n_root, 2'b01});
                if (c_try >= c_sub) begin
                    n_rem  = REM_W'(c_try - c_sub);
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = c_try[REM_W-1:0];
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
                n_x = {n_x[RAD_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= c_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= n_root;
                r_side[s] <= c_side_in;
            end
        end

        if (s < SQRT_STAGES-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_x[s]   <= n_x;
                end
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/pixel_product_with_error_top.sv
// ----------------------------------------------------------------------------
// pixel_product_with_error_top
// Pixel-wise product of two images with propagated uncertainty and merged
// quality flags, as a stall-tolerant pipeline.
// ----------------------------------------------------------------------------
// One item in, one item out, fully pipelined: a new pixel pair can be taken
// every cycle while o_stall is low. Each result passes through the 3 front-end
// stages for magnitudes, products and saturation, then squares and sum, the
// 16 square-root stages resolving two root bits each, and the output
// register. Results leave in input order. When the output is stalled a
// one-item skid register catches the item in flight; o_stall then rises and
// the whole pipeline holds until the skid drains. The block keeps no state
// between items and needs no configuration.
`default_nettype none

`include "pixel_product_with_error_top_assert.svh"

module pixel_product_with_error_top
    import ppe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    // pipeline advances while the skid register is empty
    logic              c_en;
    logic              r_skid_v;
    logic              c_mid_v;
    t_mid              c_mid;
    logic              c_res_v;
    t_side             c_side;
    logic [ROOT_W-1:0] c_root;

    assign c_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    ppe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (c_mid_v),
        .o_mid   (c_mid)
    );

    ppe_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (c_mid_v),
        .i_mid   (c_mid),
        .o_valid (c_res_v),
        .o_side  (c_side),
        .o_root  (c_root)
    );

    // error clamp and final result assembly
    logic      c_root_ovf;
    t_out_item n_res;

    assign c_root_ovf = |c_root[ROOT_W-1:ERR_W];

    always_comb begin
        n_res.product_value   = c_side.value;
        n_res.product_quality = c_side.quality;
        n_res.product_error   = (c_side.err_ovf || c_root_ovf) ? ERR_MAX
                                                                : c_root[ERR_W-1:0];
        n_res.saturated       = c_side.val_sat | c_side.err_ovf | c_root_ovf;
    end

    // output register with skid behind it
    logic      r_out_v;
    t_out_item r_out;
    t_out_item r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            // output slot free or being taken this cycle
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= c_res_v;
            end
        end else if (!r_skid_v && c_res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (!r_skid_v) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    // checks
    `PPE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")
    `PPE_ASSERT(a_skid_behind_out, r_skid_v |-> r_out_v, "skid item without output item")
    `PPE_ASSERT(a_sat_extreme, o_valid && o_item.saturated && (o_item.product_error != ERR_MAX) |-> (o_item.product_value == VAL_MAX) || (o_item.product_value == VAL_MIN), "saturated flag without clipped field")

endmodule

`default_nettype wire

### sim/tb_pixel_product_with_error_top.sv
// ----------------------------------------------------------------------------
// tb_pixel_product_with_error_top
// Self-checking bench for the pixel product-with-error pipeline. A predictor
// computes the expected product, propagated error, merged quality and
// saturation flag for every item accepted at the input. Each item leaving
// the block is compared against the oldest expected result. Corner pixels
// are sent first, then random pixels. Random gaps and stalls fall on both
// channels. One long output hold fills the pipe, and one pause drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pixel_product_with_error_top;
    import ppe_pkg::*;

    localparam int LONG_HOLD = 100;   // receiver hold, cycles
    localparam int DRAIN_CYC = 30;    // settle after last result

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    bit calm     = 1'b0;   // no random gaps or stalls while set
    bit hold_req = 1'b0;   // asks the receiver for one long hold

    pixel_product_with_error_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Expected products in input order, plus the predictor that fills them
    class product_scoreboard;
        t_out_item expected_products[$];
        int        errors = 0;

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
        endtask

        // floor(sqrt(rad)), one root bit per step from the top
        function logic [63:0] floor_sqrt(logic [63:0] rad);
            logic [63:0] acc;
            logic [63:0] trial;
            acc = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = acc | (64'd1 << b);
                if (trial * trial <= rad)
                    acc = trial;
            end
            return acc;
        endfunction

        function t_out_item predict_product(t_in_item px);
            t_out_item   res;
            logic        neg_a;
            logic        neg_b;
            logic [32:0] mag_a;
            logic [32:0] mag_b;
            logic [63:0] prod;
            logic [63:0] quot;
            logic [63:0] term_a;
            logic [63:0] term_b;
            logic [63:0] root;
            neg_a = px.first_value[VAL_W-1];
            neg_b = px.second_value[VAL_W-1];
            mag_a = neg_a ? 33'h1_0000_0000 - {1'b0, px.first_value} : {1'b0, px.first_value};
            mag_b = neg_b ? 33'h1_0000_0000 - {1'b0, px.second_value}
                          : {1'b0, px.second_value};
            res.saturated = 1'b0;

            // value: floor toward minus infinity, so a negative result rounds
            // its magnitude up
            prod = {31'b0, mag_a} * {31'b0, mag_b};
            if (neg_a != neg_b) begin
                quot = (prod + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS;
                if (quot > 64'h8000_0000) begin
                    quot          = 64'h8000_0000;
                    res.saturated = 1'b1;
                end
                res.product_value = VAL_W'(64'd0 - quot);
            end else begin
                quot = prod >> FRAC_BITS;
                if (quot > {32'b0, VAL_MAX}) begin
                    quot          = {32'b0, VAL_MAX};
                    res.saturated = 1'b1;
                end
                res.product_value = quot[VAL_W-1:0];
            end

            // error: cross terms use value magnitudes
            term_a = ({31'b0, mag_a} * {33'b0, px.second_error}) >> FRAC_BITS;
            term_b = ({31'b0, mag_b} * {33'b0, px.first_error}) >> FRAC_BITS;
            if (term_a > {33'b0, ERR_MAX} || term_b > {33'b0, ERR_MAX}) begin
                res.product_error = ERR_MAX;
                res.saturated     = 1'b1;
            end else begin
                root = floor_sqrt(term_a * term_a + term_b * term_b);
                if (root > {33'b0, ERR_MAX}) begin
                    res.product_error = ERR_MAX;
                    res.saturated     = 1'b1;
                end else begin
                    res.product_error = root[ERR_W-1:0];
                end
            end

            res.product_quality = px.first_quality | px.second_quality;
            return res;
        endfunction

        function void note_pixel(t_in_item px);
            expected_products.push_back(predict_product(px));
        endfunction

        function int pending();
            return expected_products.size();
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_products.size() == 0) begin
                report_mismatch("unexpected item", 64'(got), 64'd0);
                return;
            end
            want = expected_products.pop_front();
            if (got.product_value !== want.product_value)
                report_mismatch("product_value", 64'(got.product_value),
                                64'(want.product_value));
            if (got.product_error !== want.product_error)
                report_mismatch("product_error", 64'(got.product_error),
                                64'(want.product_error));
            if (got.product_quality !== want.product_quality)
                report_mismatch("product_quality", 64'(got.product_quality),
                                64'(want.product_quality));
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
        endtask
    endclass

    product_scoreboard board = new();

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h003F_FFFF);            // below 64.0
            2: v = 32'h0001_0000 + $urandom_range(0, 32'h3FFF) - 32'h2000;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = 32'd1;
                    2: v = 32'hFFFF_FFFF;
                    3: v = VAL_MAX;
                    4: v = VAL_MIN;
                    default: v = 32'h0001_0000;
                endcase
            end
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [ERR_W-1:0] rand_error();
        logic [ERR_W-1:0] e;
        case ($urandom_range(0, 2))
            0: e = ERR_W'($urandom());
            1: e = ERR_W'($urandom_range(0, 32'h0003_FFFF));
            default: begin
                case ($urandom_range(0, 3))
                    0: e = '0;
                    1: e = 31'd1;
                    2: e = ERR_MAX;
                    default: e = 31'h0001_0000;
                endcase
            end
        endcase
        return e;
    endfunction

    function automatic t_in_item make_pixel(logic [VAL_W-1:0] va, logic [VAL_W-1:0] vb,
                                            logic [ERR_W-1:0] ea, logic [ERR_W-1:0] eb,
                                            logic [QUAL_W-1:0] qa, logic [QUAL_W-1:0] qb);
        t_in_item px;
        px.first_value    = va;
        px.second_value   = vb;
        px.first_error    = ea;
        px.second_error   = eb;
        px.first_quality  = qa;
        px.second_quality = qb;
        return px;
    endfunction

    function automatic t_in_item rand_pixel();
        return make_pixel(rand_value(), rand_value(), rand_error(), rand_error(),
                          QUAL_W'($urandom()), QUAL_W'($urandom()));
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic send_pixel(input t_in_item px);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= px;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (board.pending() > 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                hold_left = pick_gap();
                i_stall <= (hold_left > 0);
                if (hold_left > 0)
                    hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_result(o_item);
    end

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner pixels
        send_pixel(make_pixel('0, '0, '0, '0, '0, '0));
        send_pixel(make_pixel(32'h0001_0000, 32'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                              16'h0000, 16'h0000));
        // positive value overflow, both errors overflow
        send_pixel(make_pixel(VAL_MAX, VAL_MAX, ERR_MAX, ERR_MAX, 16'hFFFF, 16'hFFFF));
        // most negative squared
        send_pixel(make_pixel(VAL_MIN, VAL_MIN, 31'd1, 31'd1, 16'h0001, 16'h8000));
        // negative value overflow
        send_pixel(make_pixel(VAL_MIN, VAL_MAX, '0, '0, 16'h00FF, 16'hFF00));
        // exactly -2^31, no clipping
        send_pixel(make_pixel(VAL_MIN, 32'h0001_0000, 31'h0000_8000, '0, 16'h0, 16'h1));
        send_pixel(make_pixel(32'h0080_0000, 32'hFF00_0000, '0, '0, 16'h0, 16'h0));
        // just above the positive limit
        send_pixel(make_pixel(32'h0080_0000, 32'h0100_0000, '0, '0, 16'h0, 16'h0));
        // truncation toward minus infinity
        send_pixel(make_pixel(32'hFFFF_FFFF, 32'd1, 31'd1, 31'd1, 16'h0, 16'h0));
        send_pixel(make_pixel(32'd1, 32'd1, 31'd1, 31'd1, 16'h0, 16'h0));
        send_pixel(make_pixel(VAL_MAX, 32'hFFFF_FFFF, 31'd3, 31'd5, 16'h0, 16'h0));
        send_pixel(make_pixel(VAL_MAX, 32'h0001_0000, '0, '0, 16'h0, 16'h0));
        send_pixel(make_pixel(32'hFFFF_0000, 32'hFFFF_0000, '0, '0, 16'h0, 16'h0));
        // root above range while each cross term fits
        send_pixel(make_pixel(32'h0001_0000, 32'h0001_0000, ERR_MAX, ERR_MAX, 16'h0, 16'h0));
        // cross term above range, most negative magnitude
        send_pixel(make_pixel(VAL_MIN, '0, '0, ERR_MAX, 16'h0, 16'h0));
        send_pixel(make_pixel(32'h0001_0000, '0, '0, 31'h4000_0000, 16'h0, 16'h0));
        // 3-4-5 triangle
        send_pixel(make_pixel(32'h0001_0000, 32'h0001_0000, 31'h0004_0000, 31'h0003_0000,
                              16'h0, 16'h0));
        send_pixel(make_pixel(32'hFFFE_0000, 32'h0003_0000, 31'h0000_8000, 31'h0000_4000,
                              16'h1234, 16'h4321));
        send_pixel(make_pixel('0, '0, ERR_MAX, ERR_MAX, 16'hAAAA, 16'h5555));
        send_pixel(make_pixel(VAL_MIN, VAL_MIN, ERR_MAX, ERR_MAX, 16'h5555, 16'hAAAA));

        // random pixels: calm stretches, one long output hold, one drain pause
        for (int seg = 0; seg < 11; seg++) begin
            calm = (seg % 4 == 1) || (seg == 5);
            if (seg == 5)
                hold_req = 1'b1;
            for (int k = 0; k < 100; k++)
                send_pixel(rand_pixel());
            if (seg == 7) begin
                i_valid <= 1'b0;
                wait_drained();
            end
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Timeout
    initial begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
